// ===== rtl/aesd_pkg.sv =====
// aesd_pkg: shared types, codes and constants for the escape sequence decoder
// no dependencies
package aesd_pkg;

  localparam int MAX_PARAMS_DEF = 16;
  localparam int PARAM_BITS_DEF = 16;
  localparam int ATTR_W = 14;
  localparam int CMD_W = 5;
  localparam int ARG_W = 16;

  typedef enum logic [1:0] {
    PS_NORMAL  = 2'd0,
    PS_ESC     = 2'd1,
    PS_BRACKET = 2'd2,
    PS_PRIVATE = 2'd3
  } pstate_t;

  typedef enum logic [2:0] {
    SQ_IDLE  = 3'd0,
    SQ_CLEAR = 3'd1,
    SQ_FOLD  = 3'd2,
    SQ_OUT   = 3'd3
  } seq_t;

  typedef enum logic [2:0] {
    FK_SGR     = 3'd0,
    FK_SET     = 3'd1,
    FK_RESET   = 3'd2,
    FK_SAVE    = 3'd3,
    FK_RESTORE = 3'd4
  } fold_t;

  localparam logic [CMD_W-1:0] CMD_PRINT    = 5'd0;
  localparam logic [CMD_W-1:0] CMD_CR       = 5'd1;
  localparam logic [CMD_W-1:0] CMD_LF       = 5'd2;
  localparam logic [CMD_W-1:0] CMD_FF       = 5'd3;
  localparam logic [CMD_W-1:0] CMD_TAB      = 5'd4;
  localparam logic [CMD_W-1:0] CMD_BS       = 5'd5;
  localparam logic [CMD_W-1:0] CMD_BELL     = 5'd6;
  localparam logic [CMD_W-1:0] CMD_UP       = 5'd7;
  localparam logic [CMD_W-1:0] CMD_DOWN     = 5'd8;
  localparam logic [CMD_W-1:0] CMD_RIGHT    = 5'd9;
  localparam logic [CMD_W-1:0] CMD_LEFT     = 5'd10;
  localparam logic [CMD_W-1:0] CMD_POS      = 5'd11;
  localparam logic [CMD_W-1:0] CMD_ED       = 5'd12;
  localparam logic [CMD_W-1:0] CMD_EL       = 5'd13;
  localparam logic [CMD_W-1:0] CMD_IL       = 5'd14;
  localparam logic [CMD_W-1:0] CMD_DL       = 5'd15;
  localparam logic [CMD_W-1:0] CMD_DCH      = 5'd16;
  localparam logic [CMD_W-1:0] CMD_ECH      = 5'd17;
  localparam logic [CMD_W-1:0] CMD_ICH      = 5'd18;
  localparam logic [CMD_W-1:0] CMD_MARGINS  = 5'd19;
  localparam logic [CMD_W-1:0] CMD_SAVE     = 5'd20;
  localparam logic [CMD_W-1:0] CMD_RESTORE  = 5'd21;
  localparam logic [CMD_W-1:0] CMD_ATTR     = 5'd22;
  localparam logic [CMD_W-1:0] CMD_SETMODE  = 5'd23;
  localparam logic [CMD_W-1:0] CMD_RESMODE  = 5'd24;
  localparam logic [CMD_W-1:0] CMD_MOUSE    = 5'd25;

  localparam logic [7:0] CH_ESC = 8'h1B;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ARG_W-1:0]  arg_first;
    logic [ARG_W-1:0]  arg_second;
    logic [ATTR_W-1:0] attribute_value;
    logic              insert_mode_flag;
    logic              newline_mode_flag;
    logic              mouse_report;
    logic              mouse_on;
  } result_t;

  // fold unit control from sequencer
  typedef struct packed {
    logic  start;
    logic  step;
    fold_t kind;
  } fold_ctl_t;

  function automatic logic [CMD_W:0] control_cmd(input logic [7:0] b);
    logic [CMD_W:0] r;
    r = '0;
    case (b)
      8'h0D: r = {1'b1, CMD_CR};
      8'h0A: r = {1'b1, CMD_LF};
      8'h0C: r = {1'b1, CMD_FF};
      8'h09: r = {1'b1, CMD_TAB};
      8'h08: r = {1'b1, CMD_BS};
      8'h07: r = {1'b1, CMD_BELL};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/aesd_fold.sv =====
// aesd_fold: shared per-parameter fold unit for sgr attributes and mode lists
// depends on aesd_pkg
module aesd_fold #(
  parameter int PARAM_BITS = aesd_pkg::PARAM_BITS_DEF
) (
  input  logic                        clk,
  input  aesd_pkg::fold_ctl_t         ctl,
  input  logic [PARAM_BITS-1:0]       param,
  input  logic [aesd_pkg::ATTR_W-1:0] attr_in,
  input  logic [aesd_pkg::ATTR_W-1:0] default_attr,
  input  logic                        mouse_cur_in,
  input  logic                        mouse_saved_in,
  output logic [aesd_pkg::ATTR_W-1:0] attr_out,
  output logic                        ins_out,
  output logic                        nl_out,
  output logic                        mrep_out,
  output logic                        mcur_out,
  output logic                        msaved_out
);

  logic [aesd_pkg::ATTR_W-1:0] attr_r, attr_nxt;
  logic ins_r, ins_nxt, nl_r, nl_nxt, mrep_r, mrep_nxt;
  logic mcur_r, mcur_nxt, msv_r, msv_nxt;
  logic is_mouse, is_tens3, is_tens4;
  logic [3:0] units;

  // compared at 32 bits so narrow parameters never alias the mouse codes
  assign is_mouse = (32'(param) == 32'd1000) || (32'(param) == 32'd1001);
  assign is_tens3 = (param >= PARAM_BITS'(30)) && (param <= PARAM_BITS'(39));
  assign is_tens4 = (param >= PARAM_BITS'(40)) && (param <= PARAM_BITS'(49));
  assign units    = is_tens4 ? 4'(param - PARAM_BITS'(40)) : 4'(param - PARAM_BITS'(30));

  always_comb begin
    attr_nxt = attr_r;
    ins_nxt  = ins_r;
    nl_nxt   = nl_r;
    mrep_nxt = mrep_r;
    mcur_nxt = mcur_r;
    msv_nxt  = msv_r;
    if (ctl.start) begin
      attr_nxt = attr_in;
      ins_nxt  = 1'b0;
      nl_nxt   = 1'b0;
      mrep_nxt = 1'b0;
      mcur_nxt = mouse_cur_in;
      msv_nxt  = mouse_saved_in;
    end else if (ctl.step) begin
      case (ctl.kind)
        aesd_pkg::FK_SGR: begin
          if (is_tens4) attr_nxt[7:4] = units;
          else if (is_tens3) attr_nxt[3:0] = units;
          else begin
            case (param)
              PARAM_BITS'(0): attr_nxt = default_attr;
              PARAM_BITS'(1): attr_nxt[8]  = 1'b1;
              PARAM_BITS'(2): attr_nxt[9]  = 1'b1;
              PARAM_BITS'(4): attr_nxt[10] = 1'b1;
              PARAM_BITS'(5): attr_nxt[11] = 1'b1;
              PARAM_BITS'(7): attr_nxt[12] = 1'b1;
              PARAM_BITS'(8): attr_nxt[13] = 1'b1;
              default: ;
            endcase
          end
        end
        aesd_pkg::FK_SET: begin
          if (param == PARAM_BITS'(4) || param == PARAM_BITS'(20)) ins_nxt = 1'b1;
          if (is_mouse) begin
            mcur_nxt = 1'b1;
            mrep_nxt = 1'b1;
          end
        end
        aesd_pkg::FK_RESET: begin
          if (param == PARAM_BITS'(4)) ins_nxt = 1'b1;
          if (param == PARAM_BITS'(20)) nl_nxt = 1'b1;
          if (is_mouse) begin
            mcur_nxt = 1'b0;
            mrep_nxt = 1'b1;
          end
        end
        aesd_pkg::FK_SAVE: begin
          if (is_mouse) msv_nxt = mcur_r;
        end
        aesd_pkg::FK_RESTORE: begin
          if (is_mouse) begin
            mcur_nxt = msv_r;
            mrep_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    attr_r <= attr_nxt;
    ins_r  <= ins_nxt;
    nl_r   <= nl_nxt;
    mrep_r <= mrep_nxt;
    mcur_r <= mcur_nxt;
    msv_r  <= msv_nxt;
  end

  assign attr_out   = attr_r;
  assign ins_out    = ins_r;
  assign nl_out     = nl_r;
  assign mrep_out   = mrep_r;
  assign mcur_out   = mcur_r;
  assign msaved_out = msv_r;

endmodule

// ===== rtl/ansi_escape_sequence_decoder_core.sv =====
// ansi_escape_sequence_decoder_core: top level, parser, parameter store and sequencer
// depends on aesd_pkg and aesd_fold
//
// output: a byte's result is registered in the cycle after the transfer; sgr and mode finals
//   first step the fold unit through each held parameter and then take the output step
// input: one byte at a time, held off while the sequencer is busy or a result waits;
//   ESC [ and ESC [ ? clear the parameter store one slot a cycle
// reset: synchronous active low; parser normal, parameters zero, attribute and
//   cfg default register zero, mouse flags off; no clearing pass after reset
module ansi_escape_sequence_decoder_core #(
  parameter int MAX_PARAMS = aesd_pkg::MAX_PARAMS_DEF,
  parameter int PARAM_BITS = aesd_pkg::PARAM_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [13:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte [7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // command [4:0], arg_first [20:5], arg_second [36:21], attribute_value [50:37],
  // insert_mode_flag [51], newline_mode_flag [52], mouse_report [53], mouse_on [54],
  // zero fill [55]
  output logic [55:0] out_tdata
);

  localparam int IDX_W = $clog2(MAX_PARAMS);
  localparam logic [PARAM_BITS-1:0] PMAX = '1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PARAMS - 1);

  logic [13:0] dflt_r;
  aesd_pkg::pstate_t ps_r, ps_nxt;
  aesd_pkg::seq_t sq_r, sq_nxt;
  aesd_pkg::fold_t fk_r, fk_nxt;
  logic [PARAM_BITS-1:0] pv_r [MAX_PARAMS];
  logic [IDX_W-1:0] pidx_r, pidx_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [13:0] attr_r, attr_nxt;
  logic mcur_r, mcur_nxt, msv_r, msv_nxt;
  logic [aesd_pkg::CMD_W-1:0] fcmd_r, fcmd_nxt;
  logic emit_r, emit_nxt;
  aesd_pkg::result_t res_r, res_nxt;
  logic ovalid_r, ovalid_nxt;

  // parameter write port
  logic pw_en;
  logic [IDX_W-1:0] pw_addr;
  logic [PARAM_BITS-1:0] pw_data;

  aesd_pkg::fold_ctl_t fctl;
  logic [13:0] f_attr;
  logic f_ins, f_nl, f_mrep, f_mcur, f_msv;

  logic [7:0] b;
  logic take;
  logic [aesd_pkg::CMD_W:0] ctl_c;
  logic [PARAM_BITS-1:0] p0, p1, pk;
  logic [PARAM_BITS+3:0] dig;

  assign b = in_tdata;
  assign in_tready = (sq_r == aesd_pkg::SQ_IDLE) && !ovalid_r;
  assign take = in_tvalid && in_tready;
  assign ctl_c = aesd_pkg::control_cmd(b);
  assign p0 = pv_r[0];
  assign p1 = pv_r[1];
  assign pk = pv_r[pidx_r];
  // decimal shift, one digit per byte; saturated at the parameter write
  assign dig = ({4'd0, pk} << 3) + ({4'd0, pk} << 1) + (PARAM_BITS + 4)'(b - 8'h30);

  function automatic logic [15:0] sat16(input logic [PARAM_BITS-1:0] v);
    logic [15:0] r;
    if (PARAM_BITS > 16 && v > PARAM_BITS'(16'hFFFF)) r = 16'hFFFF;
    else r = 16'(v);
    return r;
  endfunction

  function automatic logic [15:0] min1(input logic [PARAM_BITS-1:0] v);
    logic [15:0] r;
    r = (v == '0) ? 16'd1 : sat16(v);
    return r;
  endfunction

  aesd_fold #(.PARAM_BITS(PARAM_BITS)) u_fold (
    .clk            (clk),
    .ctl            (fctl),
    .param          (pv_r[cnt_r]),
    .attr_in        (attr_r),
    .default_attr   (dflt_r),
    .mouse_cur_in   (mcur_r),
    .mouse_saved_in (msv_r),
    .attr_out       (f_attr),
    .ins_out        (f_ins),
    .nl_out         (f_nl),
    .mrep_out       (f_mrep),
    .mcur_out       (f_mcur),
    .msaved_out     (f_msv)
  );

  always_comb begin
    logic is_final;
    is_final = 1'b0;
    ps_nxt = ps_r;
    sq_nxt = sq_r;
    fk_nxt = fk_r;
    pidx_nxt = pidx_r;
    cnt_nxt = cnt_r;
    attr_nxt = attr_r;
    mcur_nxt = mcur_r;
    msv_nxt = msv_r;
    fcmd_nxt = fcmd_r;
    emit_nxt = emit_r;
    res_nxt = res_r;
    ovalid_nxt = ovalid_r;
    pw_en = 1'b0;
    pw_addr = pidx_r;
    pw_data = '0;
    fctl = '{start: 1'b0, step: 1'b0, kind: fk_r};

    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;

    case (sq_r)
      aesd_pkg::SQ_IDLE: begin
        if (take) begin
          res_nxt = '0;
          case (ps_r)
            aesd_pkg::PS_NORMAL: begin
              if (b == aesd_pkg::CH_ESC) ps_nxt = aesd_pkg::PS_ESC;
              else if (ctl_c[aesd_pkg::CMD_W]) begin
                res_nxt.command = ctl_c[aesd_pkg::CMD_W-1:0];
                ovalid_nxt = 1'b1;
              end else if (b >= 8'h20) begin
                res_nxt.command = aesd_pkg::CMD_PRINT;
                res_nxt.arg_first = {8'd0, b};
                ovalid_nxt = 1'b1;
              end
            end
            aesd_pkg::PS_ESC: begin
              ps_nxt = aesd_pkg::PS_NORMAL;
              if (b == "[") begin
                ps_nxt = aesd_pkg::PS_BRACKET;
                sq_nxt = aesd_pkg::SQ_CLEAR;
                cnt_nxt = '0;
                pidx_nxt = '0;
              end else if (b == "A" || b == "B" || b == "C" || b == "D" ||
                           b == "J" || b == "K") begin
                is_final = 1'b1;
              end
            end
            aesd_pkg::PS_BRACKET: begin
              if (b >= "0" && b <= "9") begin
                pw_en = 1'b1;
                pw_data = (dig > {4'd0, PMAX}) ? PMAX : PARAM_BITS'(dig);
              end else if (b == ";") begin
                if (pidx_r != LAST_IDX) pidx_nxt = pidx_r + 1'b1;
              end else if (b == "?") begin
                ps_nxt = aesd_pkg::PS_PRIVATE;
                sq_nxt = aesd_pkg::SQ_CLEAR;
                cnt_nxt = '0;
                pidx_nxt = '0;
              end else if (ctl_c[aesd_pkg::CMD_W]) begin
                res_nxt.command = ctl_c[aesd_pkg::CMD_W-1:0];
                ovalid_nxt = 1'b1;
              end else begin
                ps_nxt = aesd_pkg::PS_NORMAL;
                is_final = 1'b1;
              end
            end
            default: begin
              if (b >= "0" && b <= "9") begin
                pw_en = 1'b1;
                pw_data = (dig > {4'd0, PMAX}) ? PMAX : PARAM_BITS'(dig);
              end else if (b == ";") begin
                if (pidx_r != LAST_IDX) pidx_nxt = pidx_r + 1'b1;
              end else begin
                ps_nxt = aesd_pkg::PS_NORMAL;
                if (b == "h" || b == "l" || b == "s" || b == "r") begin
                  sq_nxt = aesd_pkg::SQ_FOLD;
                  cnt_nxt = '0;
                  fctl.start = 1'b1;
                  case (b)
                    "h": begin fk_nxt = aesd_pkg::FK_SET;     fcmd_nxt = aesd_pkg::CMD_SETMODE; end
                    "l": begin fk_nxt = aesd_pkg::FK_RESET;   fcmd_nxt = aesd_pkg::CMD_RESMODE; end
                    "s": begin fk_nxt = aesd_pkg::FK_SAVE;    fcmd_nxt = aesd_pkg::CMD_MOUSE; end
                    default: begin fk_nxt = aesd_pkg::FK_RESTORE; fcmd_nxt = aesd_pkg::CMD_MOUSE; end
                  endcase
                  emit_nxt = (b != "s");
                end
              end
            end
          endcase

          if (is_final) begin
            ovalid_nxt = 1'b1;
            case (b)
              "A": begin res_nxt.command = aesd_pkg::CMD_UP;    res_nxt.arg_first = min1(p0); end
              "B": begin res_nxt.command = aesd_pkg::CMD_DOWN;  res_nxt.arg_first = min1(p0); end
              "C": begin res_nxt.command = aesd_pkg::CMD_RIGHT; res_nxt.arg_first = min1(p0); end
              "D": begin res_nxt.command = aesd_pkg::CMD_LEFT;  res_nxt.arg_first = min1(p0); end
              "H", "f": begin
                res_nxt.command = aesd_pkg::CMD_POS;
                res_nxt.arg_first = min1(p0);
                res_nxt.arg_second = min1(p1);
              end
              "J": begin res_nxt.command = aesd_pkg::CMD_ED;  res_nxt.arg_first = sat16(p0); end
              "K": begin res_nxt.command = aesd_pkg::CMD_EL;  res_nxt.arg_first = sat16(p0); end
              "L": begin res_nxt.command = aesd_pkg::CMD_IL;  res_nxt.arg_first = min1(p0); end
              "M": begin res_nxt.command = aesd_pkg::CMD_DL;  res_nxt.arg_first = min1(p0); end
              "P": begin res_nxt.command = aesd_pkg::CMD_DCH; res_nxt.arg_first = min1(p0); end
              "X": begin res_nxt.command = aesd_pkg::CMD_ECH; res_nxt.arg_first = min1(p0); end
              "@": begin res_nxt.command = aesd_pkg::CMD_ICH; res_nxt.arg_first = min1(p0); end
              "r": begin
                res_nxt.command = aesd_pkg::CMD_MARGINS;
                res_nxt.arg_first = sat16(p0);
                res_nxt.arg_second = sat16(p1);
              end
              "s": res_nxt.command = aesd_pkg::CMD_SAVE;
              "u": res_nxt.command = aesd_pkg::CMD_RESTORE;
              "m", "h", "l": begin
                ovalid_nxt = 1'b0;
                sq_nxt = aesd_pkg::SQ_FOLD;
                cnt_nxt = '0;
                fctl.start = 1'b1;
                emit_nxt = 1'b1;
                if (b == "m") begin
                  fk_nxt = aesd_pkg::FK_SGR;
                  fcmd_nxt = aesd_pkg::CMD_ATTR;
                end else if (b == "h") begin
                  fk_nxt = aesd_pkg::FK_SET;
                  fcmd_nxt = aesd_pkg::CMD_SETMODE;
                end else begin
                  fk_nxt = aesd_pkg::FK_RESET;
                  fcmd_nxt = aesd_pkg::CMD_RESMODE;
                end
              end
              default: ovalid_nxt = 1'b0;
            endcase
          end
        end
      end
      aesd_pkg::SQ_CLEAR: begin
        // one parameter slot cleared a cycle
        pw_en = 1'b1;
        pw_addr = cnt_r;
        pw_data = '0;
        if (cnt_r == LAST_IDX) sq_nxt = aesd_pkg::SQ_IDLE;
        else cnt_nxt = cnt_r + 1'b1;
      end
      aesd_pkg::SQ_FOLD: begin
        fctl.step = 1'b1;
        if (cnt_r == pidx_r) sq_nxt = aesd_pkg::SQ_OUT;
        else cnt_nxt = cnt_r + 1'b1;
      end
      aesd_pkg::SQ_OUT: begin
        sq_nxt = aesd_pkg::SQ_IDLE;
        res_nxt = '0;
        res_nxt.command = fcmd_r;
        if (fk_r == aesd_pkg::FK_SGR) begin
          // lone zero parameter loads the default outright
          attr_nxt = (pidx_r == '0 && p0 == '0) ? dflt_r : f_attr;
          res_nxt.attribute_value = attr_nxt;
        end else begin
          mcur_nxt = f_mcur;
          msv_nxt = f_msv;
          res_nxt.insert_mode_flag = f_ins;
          res_nxt.newline_mode_flag = f_nl;
          res_nxt.mouse_report = f_mrep;
          res_nxt.mouse_on = f_mcur;
        end
        ovalid_nxt = emit_r;
      end
      default: sq_nxt = aesd_pkg::SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pw_en) pv_r[pw_addr] <= pw_data;
    if (!rst_n) begin
      for (int i = 0; i < MAX_PARAMS; i++) pv_r[i] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_r   <= '0;
      ps_r     <= aesd_pkg::PS_NORMAL;
      sq_r     <= aesd_pkg::SQ_IDLE;
      fk_r     <= aesd_pkg::FK_SGR;
      pidx_r   <= '0;
      cnt_r    <= '0;
      attr_r   <= '0;
      mcur_r   <= 1'b0;
      msv_r    <= 1'b0;
      emit_r   <= 1'b0;
      ovalid_r <= 1'b0;
      fcmd_r   <= aesd_pkg::CMD_PRINT;
    end else begin
      dflt_r   <= cfg_we ? cfg_wdata : dflt_r;
      ps_r     <= ps_nxt;
      sq_r     <= sq_nxt;
      fk_r     <= fk_nxt;
      pidx_r   <= pidx_nxt;
      cnt_r    <= cnt_nxt;
      // attribute changes only on sgr finals
      attr_r   <= attr_nxt;
      mcur_r   <= mcur_nxt;
      msv_r    <= msv_nxt;
      emit_r   <= emit_nxt;
      ovalid_r <= ovalid_nxt;
      fcmd_r   <= fcmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = {1'b0, res_r.mouse_on, res_r.mouse_report, res_r.newline_mode_flag,
                      res_r.insert_mode_flag, res_r.attribute_value, res_r.arg_second,
                      res_r.arg_first, res_r.command};

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_r != aesd_pkg::SQ_IDLE) |-> !in_tready)
    else $error("input accepted while sequencer busy");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped under stall");
  a_fold_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_r == aesd_pkg::SQ_FOLD) |-> (cnt_r <= pidx_r))
    else $error("fold ran past held parameters");

endmodule
